FILE: design/owsm_pkg.sv
// Shared types, constants and helpers for the omni wheel speed mixer.
// Used by every module of the block.
package owsm_pkg;

    localparam int unsigned C_WHEELS = 4;
    localparam int unsigned C_Q_BITS = 8;

    // Q1.15 wheel-angle coefficients and the Q6.7 rotation gain (22.5 * 128)
    localparam logic signed [15:0] C_COEF_707  = 16'sd23167;
    localparam logic signed [15:0] C_COEF_866  = 16'sd28377;
    localparam logic signed [15:0] C_COEF_HALF = 16'sd16384;
    localparam logic signed [12:0] C_TURN_GAIN = 13'sd2880;

    // Speed = raw * 127 / 9830400, and 9830400 = 150 << 16
    localparam logic [7:0]         C_LIM_STEP  = 8'd150;
    localparam int unsigned        C_LIM_SHIFT = 16;
    localparam logic [26:0]        C_GAIN_DEN  = 27'd9830400;
    localparam logic signed [35:0] C_MID_NUM   = 36'sd1253376000;

    localparam logic [6:0] C_LIM_RESET = 7'd80;
    localparam logic [7:0] C_BYTE_MIN  = 8'd1;
    localparam logic [7:0] C_BYTE_MAX  = 8'd254;

    // APB map: register index sits at paddr[2]
    localparam int unsigned C_APB_AW          = 3;
    localparam logic        C_REG_MAX_SPEED   = 1'b0;

    typedef logic signed [26:0] t_raw;
    typedef logic [25:0]        t_mag;
    typedef logic signed [33:0] t_prod;
    typedef logic [34:0]        t_num;
    typedef logic [26:0]        t_den;
    typedef logic [7:0]         t_byte;

    typedef struct packed {
        t_raw  [C_WHEELS-1:0] raw;
        t_byte                kick;
    } t_mix_word;

    typedef struct packed {
        t_num  [C_WHEELS-1:0] num;
        t_den                 den;
        t_byte                kick;
    } t_div_word;

    typedef t_byte [C_WHEELS-1:0] t_quad_byte;

    function automatic t_byte clamp_byte(input t_byte q);
        t_byte v;
        if (q < C_BYTE_MIN) begin
            v = C_BYTE_MIN;
        end else if (q > C_BYTE_MAX) begin
            v = C_BYTE_MAX;
        end else begin
            v = q;
        end
        return v;
    endfunction

endpackage

FILE: design/owsm_cmd_if.sv
// Command channel: body velocity and kick request, valid/ready handshake.
// Depends on nothing; widths are the fixed command field widths.
interface owsm_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] vel_x;
    logic signed [10:0] vel_y;
    logic signed [11:0] turn_rate;
    logic               kick_request;
    logic [7:0]         kick_duration;

    modport source (
        output valid, vel_x, vel_y, turn_rate, kick_request, kick_duration,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, turn_rate, kick_request, kick_duration,
        output ready
    );
endinterface

FILE: design/owsm_whl_if.sv
// Wheel channel: four drive bytes and the kick byte, valid/ready handshake.
// Depends on nothing; all fields are bytes.
interface owsm_whl_if;
    logic       valid;
    logic       ready;
    logic [7:0] wheel_a;
    logic [7:0] wheel_b;
    logic [7:0] wheel_c;
    logic [7:0] wheel_d;
    logic [7:0] kick_byte;

    modport source (
        output valid, wheel_a, wheel_b, wheel_c, wheel_d, kick_byte,
        input  ready
    );
    modport sink (
        input  valid, wheel_a, wheel_b, wheel_c, wheel_d, kick_byte,
        output ready
    );
endinterface

FILE: design/omni_wheel_speed_mixer.sv
// Top level of the omni wheel speed mixer: command in, wheel bytes out.
// Depends on owsm_pkg, owsm_cmd_if, owsm_whl_if, owsm_cfg_regs, owsm_mix,
// owsm_norm and owsm_divider.
//
//  channel   | role   | handshake     | word
//  ----------+--------+---------------+---------------------------------------------
//  i_cmd     | sink   | valid / ready | vel_x, vel_y, turn_rate, kick_request/duration
//  o_whl     | source | valid / ready | wheel_a..wheel_d, kick_byte
//  APB       | slave  | psel/penable  | max_wheel_speed at byte address 0
//
// A word is accepted every cycle while the pipe flows. The path is 12
// registers deep (1 mix stage, 3 peak/scale stages, 8 divider stages, one
// quotient bit each); most of that depth is the divider.
// Reset is synchronous, active low: it clears every stage valid bit and
// loads the speed limit with 80. A stall on o_whl freezes every stage in
// place, so nothing is dropped or repeated.
module omni_wheel_speed_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owsm_cmd_if.sink                       i_cmd,
    owsm_whl_if.source                     o_whl,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [owsm_pkg::C_APB_AW-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                 w_adv;
    logic [6:0]           w_lim;
    logic                 w_mix_vld;
    owsm_pkg::t_mix_word  w_mix_word;
    logic                 w_norm_vld;
    owsm_pkg::t_div_word  w_norm_word;
    logic                 w_div_vld;
    owsm_pkg::t_quad_byte w_div_q;
    owsm_pkg::t_byte      w_div_kick;

    // Advance the whole pipe unless a finished word sits unclaimed at the
    // output; the last divider stage doubles as the output register.
    assign w_adv       = !w_div_vld || o_whl.ready;
    assign i_cmd.ready = w_adv;

    owsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_lim   (w_lim)
    );

    // Mix velocity into four raw wheel sums, fold the kick byte in early.
    owsm_mix u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_vld           (i_cmd.valid),
        .i_vel_x         (i_cmd.vel_x),
        .i_vel_y         (i_cmd.vel_y),
        .i_turn_rate     (i_cmd.turn_rate),
        .i_kick_request  (i_cmd.kick_request),
        .i_kick_duration (i_cmd.kick_duration),
        .o_vld           (w_mix_vld),
        .o_word          (w_mix_word)
    );

    // Find the peak, decide on scaling, and build one dividend per wheel
    // with a shared divisor: twice the peak when scaling, the gain
    // denominator otherwise. Either way the quotient is the drive byte.
    owsm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_lim   (w_lim),
        .i_vld   (w_mix_vld),
        .i_word  (w_mix_word),
        .o_vld   (w_norm_vld),
        .o_word  (w_norm_word)
    );

    owsm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_norm_vld),
        .i_word  (w_norm_word),
        .o_vld   (w_div_vld),
        .o_q     (w_div_q),
        .o_kick  (w_div_kick)
    );

    // Clamp the floored quotient into the legal drive range.
    assign o_whl.valid     = w_div_vld;
    assign o_whl.wheel_a   = owsm_pkg::clamp_byte(w_div_q[0]);
    assign o_whl.wheel_b   = owsm_pkg::clamp_byte(w_div_q[1]);
    assign o_whl.wheel_c   = owsm_pkg::clamp_byte(w_div_q[2]);
    assign o_whl.wheel_d   = owsm_pkg::clamp_byte(w_div_q[3]);
    assign o_whl.kick_byte = w_div_kick;

    // a held output word must block new commands
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_whl.valid && !o_whl.ready |-> !i_cmd.ready)
        else $error("command accepted while output stalled");

endmodule

FILE: design/owsm_cfg_regs.sv
// APB register file holding the wheel speed limit.
// Depends on owsm_pkg for the register map and reset value.
module owsm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [owsm_pkg::C_APB_AW-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [6:0]                       o_lim
);

    logic       w_sel_lim;
    logic [6:0] r_lim;

    assign w_sel_lim = (paddr[2] == owsm_pkg::C_REG_MAX_SPEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= owsm_pkg::C_LIM_RESET;
        end else if (psel && penable && pwrite && w_sel_lim) begin
            r_lim <= pwdata[6:0];
        end
    end

    assign prdata = w_sel_lim ? {25'd0, r_lim} : 32'd0;
    assign pready = 1'b1;
    assign o_lim  = r_lim;

endmodule

FILE: design/owsm_mix.sv
// Mixing stage: body velocity to four raw wheel sums in 2^-15 units.
// Depends on owsm_pkg for coefficients and the stage word type.
module owsm_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  logic signed [10:0]    i_vel_x,
    input  logic signed [10:0]    i_vel_y,
    input  logic signed [11:0]    i_turn_rate,
    input  logic                  i_kick_request,
    input  logic [7:0]            i_kick_duration,
    output logic                  o_vld,
    output owsm_pkg::t_mix_word   o_word
);

    logic signed [11:0]  w_sum;
    logic signed [11:0]  w_dif;
    logic signed [23:0]  w_rot;
    owsm_pkg::t_raw      w_p707s;
    owsm_pkg::t_raw      w_p707d;
    owsm_pkg::t_raw      w_p866;
    owsm_pkg::t_raw      w_phalf;
    owsm_pkg::t_mix_word n_word;
    owsm_pkg::t_mix_word r_word;
    logic                r_vld;

    assign w_sum   = i_vel_x + i_vel_y;
    assign w_dif   = i_vel_x - i_vel_y;
    assign w_rot   = i_turn_rate * owsm_pkg::C_TURN_GAIN;
    assign w_p707s = owsm_pkg::C_COEF_707 * w_sum;
    assign w_p707d = owsm_pkg::C_COEF_707 * w_dif;
    assign w_p866  = owsm_pkg::C_COEF_866 * i_vel_x;
    assign w_phalf = owsm_pkg::C_COEF_HALF * i_vel_y;

    always_comb begin
        n_word.raw[0] = w_rot - w_p707s;
        n_word.raw[1] = w_phalf - w_p866 + w_rot;
        n_word.raw[2] = w_p866 + w_phalf + w_rot;
        n_word.raw[3] = w_p707d + w_rot;
        n_word.kick   = i_kick_request ? i_kick_duration : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

FILE: design/owsm_norm.sv
// Peak search, limit check and dividend/divisor build, three stages.
// Depends on owsm_pkg for word types and gain constants.
module owsm_norm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [6:0]            i_lim,
    input  logic                  i_vld,
    input  owsm_pkg::t_mix_word   i_word,
    output logic                  o_vld,
    output owsm_pkg::t_div_word   o_word
);

    localparam int unsigned W = owsm_pkg::C_WHEELS;

    // stage A: magnitudes and peak
    owsm_pkg::t_mag      w_mag [W];
    owsm_pkg::t_mag      w_m01;
    owsm_pkg::t_mag      w_m23;
    owsm_pkg::t_mag      w_peak;
    owsm_pkg::t_mix_word r_a_word;
    owsm_pkg::t_mag      r_a_peak;
    logic                r_a_vld;

    always_comb begin
        for (int i = 0; i < W; i++) begin
            w_mag[i] = i_word.raw[i][26] ? owsm_pkg::t_mag'(-$signed(i_word.raw[i]))
                                         : owsm_pkg::t_mag'(i_word.raw[i]);
        end
        w_m01  = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
        w_m23  = (w_mag[2] > w_mag[3]) ? w_mag[2] : w_mag[3];
        w_peak = (w_m01 > w_m23) ? w_m01 : w_m23;
    end

    // stage B: limit compare and raw * limit
    logic [32:0]         w_pk127;
    logic [14:0]         w_lim_gain;
    logic [30:0]         w_lim_den;
    logic                n_b_scaled;
    owsm_pkg::t_prod     n_b_prod [W];
    owsm_pkg::t_prod     r_b_prod [W];
    owsm_pkg::t_mix_word r_b_word;
    owsm_pkg::t_mag      r_b_peak;
    logic                r_b_scaled;
    logic                r_b_vld;

    assign w_pk127    = {r_a_peak, 7'd0} - {7'd0, r_a_peak};
    assign w_lim_gain = 15'(i_lim) * 15'(owsm_pkg::C_LIM_STEP);
    assign w_lim_den  = 31'(w_lim_gain) << owsm_pkg::C_LIM_SHIFT;
    assign n_b_scaled = w_pk127 > 33'(w_lim_den);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            n_b_prod[i] = $signed(r_a_word.raw[i]) * $signed({1'b0, i_lim});
        end
    end

    // stage C: dividend and divisor
    owsm_pkg::t_div_word n_c_word;
    owsm_pkg::t_div_word r_c_word;
    logic                r_c_vld;

    always_comb begin
        logic signed [35:0] v_pk;
        logic signed [35:0] v_raw;
        logic signed [35:0] v_prod;
        logic signed [35:0] v_num_s;
        logic signed [35:0] v_num_u;
        v_pk = $signed({10'd0, r_b_peak});
        for (int i = 0; i < W; i++) begin
            v_raw   = 36'($signed(r_b_word.raw[i]));
            v_prod  = 36'(r_b_prod[i]);
            v_num_s = (v_pk <<< 8) - v_pk - (v_prod <<< 1);
            v_num_u = owsm_pkg::C_MID_NUM - ((v_raw <<< 7) - v_raw);
            n_c_word.num[i] = r_b_scaled ? v_num_s[34:0] : v_num_u[34:0];
        end
        n_c_word.den  = r_b_scaled ? {r_b_peak, 1'b0} : owsm_pkg::C_GAIN_DEN;
        n_c_word.kick = r_b_word.kick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_word   <= i_word;
            r_a_peak   <= w_peak;
            r_b_word   <= r_a_word;
            r_b_peak   <= r_a_peak;
            r_b_scaled <= n_b_scaled;
            r_b_prod   <= n_b_prod;
            r_c_word   <= n_c_word;
        end
    end

    assign o_vld  = r_c_vld;
    assign o_word = r_c_word;

    // scaling divides by twice the peak, so the peak must be nonzero then
    a_scaled_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && r_b_scaled |-> r_b_peak != '0)
        else $error("scaled word with zero peak");

endmodule

FILE: design/owsm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Depends on owsm_pkg for word types and the quotient width.
module owsm_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  owsm_pkg::t_div_word   i_word,
    output logic                  o_vld,
    output owsm_pkg::t_quad_byte  o_q,
    output owsm_pkg::t_byte       o_kick
);

    localparam int unsigned NSTEP = owsm_pkg::C_Q_BITS;
    localparam int unsigned W     = owsm_pkg::C_WHEELS;

    logic            r_vld  [NSTEP];
    owsm_pkg::t_byte r_kick [NSTEP];
    owsm_pkg::t_byte r_q    [NSTEP][W];
    owsm_pkg::t_num  r_rem  [NSTEP-1][W];
    owsm_pkg::t_den  r_den  [NSTEP-1];

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int unsigned K = NSTEP - 1 - s;

        logic            w_vin;
        owsm_pkg::t_byte w_kin;
        owsm_pkg::t_den  w_din;

        if (s == 0) begin : g_head
            assign w_vin = i_vld;
            assign w_kin = i_word.kick;
            assign w_din = i_word.den;
        end else begin : g_body
            assign w_vin = r_vld[s-1];
            assign w_kin = r_kick[s-1];
            assign w_din = r_den[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_kick[s] <= w_kin;
            end
        end

        if (s < NSTEP - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_den[s] <= w_din;
                end
            end
        end

        for (genvar l = 0; l < W; l++) begin : g_lane
            owsm_pkg::t_num  w_rin;
            owsm_pkg::t_byte w_qin;
            owsm_pkg::t_num  w_dsh;
            logic            w_ge;
            owsm_pkg::t_byte n_q;

            if (s == 0) begin : g_head
                assign w_rin = i_word.num[l];
                assign w_qin = '0;
            end else begin : g_body
                assign w_rin = r_rem[s-1][l];
                assign w_qin = r_q[s-1][l];
            end

            // try subtracting the divisor at this bit weight
            assign w_dsh = owsm_pkg::t_num'(w_din) << K;
            assign w_ge  = w_rin >= w_dsh;
            assign n_q   = w_qin | (owsm_pkg::t_byte'(w_ge) << K);

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_q[s][l] <= n_q;
                end
            end

            if (s < NSTEP - 1) begin : g_rem
                owsm_pkg::t_num n_rem;
                assign n_rem = w_ge ? w_rin - w_dsh : w_rin;
                always_ff @(posedge i_clk) begin
                    if (i_adv) begin
                        r_rem[s][l] <= n_rem;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < W; l++) begin : g_out
        assign o_q[l] = r_q[NSTEP-1][l];
    end

    assign o_vld  = r_vld[NSTEP-1];
    assign o_kick = r_kick[NSTEP-1];

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_den[0] != '0)
        else $error("divider entered with zero divisor");

    // dividends are built below 255 divisors, so no quotient reaches 255
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTEP-1] |-> (o_q[0] <= owsm_pkg::C_BYTE_MAX) &&
                           (o_q[1] <= owsm_pkg::C_BYTE_MAX) &&
                           (o_q[2] <= owsm_pkg::C_BYTE_MAX) &&
                           (o_q[3] <= owsm_pkg::C_BYTE_MAX))
        else $error("quotient out of byte range");

endmodule
